/* sv/hash_table_chain_or_quadratic_probe_defines.svh */
// Assertion macros shared by the hash table RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef HASH_TABLE_CHAIN_OR_QUADRATIC_PROBE_DEFINES_SVH
`define HASH_TABLE_CHAIN_OR_QUADRATIC_PROBE_DEFINES_SVH

// Property must hold at every edge outside reset.
`define HT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define HT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* sv/htcq_pkg.sv */
// Shared types and constants for the hash table block.
// No dependencies; imported by htcq_front, htcq_back and the top level.
`default_nettype none
package htcq_pkg;
  localparam int TABLE_SIZE = 128;
  localparam int POOL_SIZE  = 256;
  localparam int TW = $clog2(TABLE_SIZE);
  localparam int PW = $clog2(POOL_SIZE);
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int KEY_W = 8;
  localparam int VAL_W = 32;
  localparam int QDEPTH = 2;
  localparam int QW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7fff_ffff;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic MODE_CHAIN = 1'b0;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_CHAIN_PUT = 2'd0,
    OP_CHAIN_GET = 2'd1,
    OP_QUAD_PUT  = 2'd2,
    OP_QUAD_GET  = 2'd3
  } op_t;

  typedef struct packed {
    op_t op;
    logic [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } cmd_t;
endpackage
`default_nettype wire

/* sv/htcq_ram.sv */
// Generic single write port RAM with one registered read port.
// Standalone; used for every table store of the block.
`default_nettype none
module htcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/htcq_front.sv */
// Front end: accepts requests, classifies them by mode and function,
// and queues them for the back end. Depends on htcq_pkg.
`default_nettype none
module htcq_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           func,
  input  wire logic [htcq_pkg::KEY_W-1:0]     key,
  input  wire logic signed [htcq_pkg::VAL_W-1:0] value,
  input  wire logic                           mode_we,
  input  wire logic                           mode_wdata,
  output logic                                busy,
  output logic                                cmd_valid,
  output htcq_pkg::cmd_t                      cmd,
  input  wire logic                           cmd_take
);
  import htcq_pkg::*;

  logic collision_mode;
  cmd_t entries [QDEPTH];
  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;
  logic push, pop;
  cmd_t incoming;

  always_comb begin
    incoming.key = key;
    incoming.value = value;
    if (collision_mode == MODE_CHAIN) begin
      incoming.op = (func == FUNC_PUT) ? OP_CHAIN_PUT : OP_CHAIN_GET;
    end else begin
      incoming.op = (func == FUNC_PUT) ? OP_QUAD_PUT : OP_QUAD_GET;
    end
  end

  assign busy = (count == QCW'(QDEPTH));
  assign push = start && !busy;
  assign cmd_valid = (count != '0);
  assign pop = cmd_take && cmd_valid;
  assign cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      collision_mode <= MODE_CHAIN;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (mode_we) begin
        collision_mode <= mode_wdata;
      end
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end
endmodule
`default_nettype wire

/* sv/htcq_back.sv */
// Back end: executes queued requests against the chain and slot stores.
// Depends on htcq_pkg, htcq_ram and the assertion macro header.
`default_nettype none
`include "hash_table_chain_or_quadratic_probe_defines.svh"
module htcq_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  input  wire htcq_pkg::cmd_t                 cmd,
  output logic                                cmd_take,
  output logic                                done,
  output logic signed [htcq_pkg::VAL_W-1:0]   result_value,
  output logic [1:0]                          status
);
  import htcq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_CP_RD   = 10'b0000000010,
    S_CP_WR   = 10'b0000000100,
    S_CP_LINK = 10'b0000001000,
    S_CG_RD   = 10'b0000010000,
    S_CG_HEAD = 10'b0000100000,
    S_CG_NODE = 10'b0001000000,
    S_QP      = 10'b0010000000,
    S_QG      = 10'b0100000000,
    S_QG_CMP  = 10'b1000000000
  } state_t;

  localparam int NDW = KEY_W + VAL_W;
  localparam int LKW = PW + 1;
  localparam int BKW = 2 * PW;

  state_t state;
  cmd_t cur;
  logic [PW-1:0] nidx, tail;
  logic [TW:0] probe_i;
  logic [TW-1:0] slot;
  logic [CW-1:0] pool_used;
  logic [TABLE_SIZE-1:0] slot_used;
  logic [TABLE_SIZE-1:0] bucket_nonempty;
  logic [TW-1:0] bkt;
  logic last_probe;
  logic [TW-1:0] slot_adv;

  logic nd_we, lk_we, bk_we, sl_we;
  logic [PW-1:0] node_raddr, lk_waddr;
  logic [LKW-1:0] lk_wdata, lk_rdata;
  logic [NDW-1:0] nd_rdata, sl_rdata;
  logic [BKW-1:0] bk_wdata, bk_rdata;

  assign bkt = TW'(32'(cur.key) % TABLE_SIZE);
  assign last_probe = (probe_i == (TW+1)'(TABLE_SIZE - 1));
  // (i+1)^2 = i^2 + 2i + 1
  assign slot_adv = slot + TW'({probe_i, 1'b1});
  assign cmd_take = (state == S_IDLE) && cmd_valid;

  always_comb begin
    nd_we = (state == S_CP_WR);
    bk_we = (state == S_CP_WR);
    lk_we = (state == S_CP_WR) || (state == S_CP_LINK);
    sl_we = (state == S_QP) && !slot_used[slot];
    lk_waddr = (state == S_CP_LINK) ? tail : nidx;
    lk_wdata = (state == S_CP_LINK) ? {nidx, 1'b1} : '0;
    bk_wdata = bucket_nonempty[bkt] ? {bk_rdata[BKW-1:PW], nidx} : {nidx, nidx};
    node_raddr = (state == S_CG_HEAD) ? bk_rdata[BKW-1:PW] : lk_rdata[LKW-1:1];
  end

  htcq_ram #(.WIDTH(NDW), .DEPTH(POOL_SIZE)) u_node_data (
    .clk(clk), .we(nd_we), .waddr(nidx), .wdata({cur.key, cur.value}),
    .raddr(node_raddr), .rdata(nd_rdata)
  );
  htcq_ram #(.WIDTH(LKW), .DEPTH(POOL_SIZE)) u_node_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(node_raddr), .rdata(lk_rdata)
  );
  htcq_ram #(.WIDTH(BKW), .DEPTH(TABLE_SIZE)) u_bucket (
    .clk(clk), .we(bk_we), .waddr(bkt), .wdata(bk_wdata),
    .raddr(bkt), .rdata(bk_rdata)
  );
  htcq_ram #(.WIDTH(NDW), .DEPTH(TABLE_SIZE)) u_slot (
    .clk(clk), .we(sl_we), .waddr(slot), .wdata({cur.key, cur.value}),
    .raddr(slot), .rdata(sl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      pool_used <= '0;
      slot_used <= '0;
      bucket_nonempty <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            slot <= TW'(32'(cmd.key) % TABLE_SIZE);
            probe_i <= '0;
            case (cmd.op)
              OP_CHAIN_PUT: state <= S_CP_RD;
              OP_CHAIN_GET: state <= S_CG_RD;
              OP_QUAD_PUT:  state <= S_QP;
              OP_QUAD_GET:  state <= S_QG;
              default:      state <= S_IDLE;
            endcase
          end
        end
        S_CP_RD: begin
          if (pool_used == CW'(POOL_SIZE)) begin
            done <= 1'b1;
            status <= ST_FULL;
            result_value <= '0;
            state <= S_IDLE;
          end else begin
            nidx <= pool_used[PW-1:0];
            state <= S_CP_WR;
          end
        end
        S_CP_WR: begin
          pool_used <= pool_used + 1'b1;
          bucket_nonempty[bkt] <= 1'b1;
          tail <= bk_rdata[PW-1:0];
          if (bucket_nonempty[bkt]) begin
            state <= S_CP_LINK;
          end else begin
            done <= 1'b1;
            status <= ST_OK;
            result_value <= '0;
            state <= S_IDLE;
          end
        end
        S_CP_LINK: begin
          done <= 1'b1;
          status <= ST_OK;
          result_value <= '0;
          state <= S_IDLE;
        end
        S_CG_RD: begin
          if (!bucket_nonempty[bkt]) begin
            done <= 1'b1;
            status <= ST_MISS;
            result_value <= INT_MAX;
            state <= S_IDLE;
          end else begin
            state <= S_CG_HEAD;
          end
        end
        S_CG_HEAD: state <= S_CG_NODE;
        S_CG_NODE: begin
          if (nd_rdata[NDW-1:VAL_W] == cur.key) begin
            done <= 1'b1;
            status <= ST_OK;
            result_value <= nd_rdata[VAL_W-1:0];
            state <= S_IDLE;
          end else if (!lk_rdata[0]) begin
            done <= 1'b1;
            status <= ST_MISS;
            result_value <= INT_MAX;
            state <= S_IDLE;
          end
        end
        S_QP: begin
          if (!slot_used[slot]) begin
            slot_used[slot] <= 1'b1;
            done <= 1'b1;
            status <= ST_OK;
            result_value <= '0;
            state <= S_IDLE;
          end else if (last_probe) begin
            done <= 1'b1;
            status <= ST_FULL;
            result_value <= '0;
            state <= S_IDLE;
          end else begin
            slot <= slot_adv;
            probe_i <= probe_i + 1'b1;
          end
        end
        S_QG: begin
          if (!slot_used[slot]) begin
            done <= 1'b1;
            status <= ST_MISS;
            result_value <= INT_MAX;
            state <= S_IDLE;
          end else begin
            state <= S_QG_CMP;
          end
        end
        S_QG_CMP: begin
          if (sl_rdata[NDW-1:VAL_W] == cur.key) begin
            done <= 1'b1;
            status <= ST_OK;
            result_value <= sl_rdata[VAL_W-1:0];
            state <= S_IDLE;
          end else if (last_probe) begin
            done <= 1'b1;
            status <= ST_MISS;
            result_value <= INT_MAX;
            state <= S_IDLE;
          end else begin
            slot <= slot_adv;
            probe_i <= probe_i + 1'b1;
            state <= S_QG;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HT_NEVER(a_pool_bound, clk, rst, pool_used > CW'(POOL_SIZE), "pool count overran")
  `HT_ASSERT(a_done_ends_work, clk, rst, done |-> state == S_IDLE, "result while still working")
  `HT_ASSERT(a_take_idle, clk, rst, cmd_take |=> !done, "result in the cycle after a pop")
  `HT_NEVER(a_status_code, clk, rst, done && status == 2'd3, "undefined status code")
endmodule
`default_nettype wire

/* sv/hash_table_chain_or_quadratic_probe.sv */
// Hash table, 8-bit keys and 32-bit values, chaining or quadratic probing.
// Top level; depends on htcq_pkg, htcq_front and htcq_back.
//
// Requests are taken when start is high and busy is low; a two-entry queue
// lets two requests wait while one executes. Each request produces exactly one
// result, shown for one cycle with done high; the receiver cannot stall it.
// After leaving the queue, a chaining put reads the bucket, writes the node and
// bucket entry, and links the old tail if the bucket was not empty; a chaining
// get reads the bucket, then the head and one node per step; a quadratic put
// checks one slot per probe and a quadratic get reads, then compares, each slot
// (up to TABLE_SIZE probes). The back end returns to idle between requests. A
// single read port per table RAM means one node or slot is inspected per step.
`default_nettype none
module hash_table_chain_or_quadratic_probe (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              func,
  input  wire logic [htcq_pkg::KEY_W-1:0]        key,
  input  wire logic signed [htcq_pkg::VAL_W-1:0] value,
  input  wire logic                              mode_we,
  input  wire logic                              mode_wdata,
  output logic                                   done,
  output logic signed [htcq_pkg::VAL_W-1:0]      result_value,
  output logic [1:0]                             status
);
  import htcq_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  htcq_front u_front (
    .clk(clk), .rst(rst), .start(start), .func(func), .key(key), .value(value),
    .mode_we(mode_we), .mode_wdata(mode_wdata), .busy(busy),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  htcq_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .done(done), .result_value(result_value), .status(status)
  );
endmodule
`default_nettype wire
